// ===== design/i2rd_pkg.sv =====
// ----------------------------------------------------------------------------
// i2rd_pkg: shared constants and helpers for integer_to_radix_digits
// Field widths, stream packing and the digit-to-ASCII mapping.
// ----------------------------------------------------------------------------
package i2rd_pkg;

  // Width of the value field on the stream, and the part of it that is used
  localparam int VALUE_WIDTH = 63;
  localparam int VALUE_BITS  = 63;
  localparam int BASE_WIDTH  = 6;
  localparam int DIGIT_WIDTH = 6;
  localparam int CHAR_WIDTH  = 7;

  localparam int S_DATA_WIDTH = ((VALUE_WIDTH + BASE_WIDTH + 7) / 8) * 8;
  localparam int M_DATA_WIDTH = ((CHAR_WIDTH + 7) / 8) * 8;

  // Digit stack depth: base 2 gives one digit per used value bit
  localparam int STACK_DEPTH = VALUE_BITS;
  localparam int CNT_WIDTH   = $clog2(STACK_DEPTH + 1);
  localparam int BIT_WIDTH   = $clog2(VALUE_BITS);

  localparam logic [BASE_WIDTH-1:0] BASE_MIN = BASE_WIDTH'(2);
  localparam logic [BASE_WIDTH-1:0] BASE_MAX = BASE_WIDTH'(36);

  localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO   = CHAR_WIDTH'(48);  // '0'
  localparam logic [CHAR_WIDTH-1:0] CHAR_A_OFFS = CHAR_WIDTH'(87);  // 'a' - 10

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EMIT
  } state_t;

  // Digit 0..35 to '0'-'9', 'a'-'z'
  function automatic logic [CHAR_WIDTH-1:0] digit_to_char(input logic [DIGIT_WIDTH-1:0] d);
    logic [CHAR_WIDTH-1:0] dx;
    dx = CHAR_WIDTH'(d);
    if (d < DIGIT_WIDTH'(10)) begin
      return CHAR_ZERO + dx;
    end else begin
      return CHAR_A_OFFS + dx;
    end
  endfunction

endpackage

// ===== design/integer_to_radix_digits.sv =====
// ----------------------------------------------------------------------------
// integer_to_radix_digits: integer to ASCII digits in radix 2..36
// Operation: each digit takes one pass of bit-serial division (one
//   quotient bit per cycle), then digits leave one per cycle while m_tready is high, MSD first.
// Bad radix: the single error result is offered the cycle after the request.
// Throughput: one request at a time; the next is taken after the last result.
// Reset: synchronous, returns to idle and drops any conversion in flight.
// ----------------------------------------------------------------------------
module integer_to_radix_digits
  import i2rd_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    s_tvalid,
  output logic                    s_tready,
  input  logic [S_DATA_WIDTH-1:0] s_tdata,   // value[62:0], base[68:63], zero pad
  output logic                    m_tvalid,
  input  logic                    m_tready,
  output logic [M_DATA_WIDTH-1:0] m_tdata,   // digit_char[6:0], zero pad
  output logic                    m_tlast,
  output logic                    m_tuser    // bad_base
);

  state_t state, state_next;

  logic [VALUE_BITS-1:0]  v;       // dividend in, quotient shifts in at bottom
  logic [DIGIT_WIDTH-1:0] rem;
  logic [BASE_WIDTH-1:0]  radix;
  logic                   qnz;     // any quotient bit set this pass
  logic [BIT_WIDTH-1:0]   bitcnt;
  logic [CNT_WIDTH-1:0]   cnt;
  logic                   bad;
  logic [DIGIT_WIDTH-1:0] stk [STACK_DEPTH];

  logic                   in_acc, out_acc;
  logic [BASE_WIDTH-1:0]  in_base;
  logic                   in_bad;
  logic [DIGIT_WIDTH:0]   rem_sh;
  logic                   qbit;
  logic [DIGIT_WIDTH-1:0] rem_next;
  logic                   pass_done, more;
  logic                   emit_done;

  assign in_acc  = s_tvalid && s_tready;
  assign out_acc = m_tvalid && m_tready;
  assign in_base = s_tdata[VALUE_WIDTH +: BASE_WIDTH];
  assign in_bad  = (in_base < BASE_MIN) || (in_base > BASE_MAX);

  // Restoring division step: one quotient bit per cycle
  assign rem_sh   = {rem, v[VALUE_BITS-1]};
  assign qbit     = rem_sh >= {1'b0, radix};
  assign rem_next = qbit ? DIGIT_WIDTH'(rem_sh - {1'b0, radix}) : rem_sh[DIGIT_WIDTH-1:0];

  assign pass_done = (bitcnt == '0);
  assign more      = qnz || qbit;
  assign emit_done = bad || (cnt == CNT_WIDTH'(1));

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_acc) begin
          state_next = in_bad ? ST_EMIT : ST_DIV;
        end
      end
      ST_DIV: begin
        if (pass_done && !more) begin
          state_next = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (out_acc && emit_done) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    s_tready = 1'b0;
    m_tvalid = 1'b0;
    unique case (state)
      ST_IDLE: s_tready = 1'b1;
      ST_DIV:  ;
      ST_EMIT: m_tvalid = 1'b1;
      default: ;
    endcase
  end

  assign m_tdata = M_DATA_WIDTH'(bad ? '0 : digit_to_char(stk[0]));
  assign m_tlast = emit_done;
  assign m_tuser = bad;

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= ST_IDLE;
      cnt    <= '0;
      bad    <= 1'b0;
      qnz    <= 1'b0;
      bitcnt <= '0;
    end else begin
      state <= state_next;
      unique case (state)
        ST_IDLE: begin
          if (in_acc) begin
            bad    <= in_bad;
            cnt    <= '0;
            qnz    <= 1'b0;
            bitcnt <= BIT_WIDTH'(VALUE_BITS - 1);
          end
        end
        ST_DIV: begin
          if (pass_done) begin
            cnt    <= cnt + CNT_WIDTH'(1);
            qnz    <= 1'b0;
            bitcnt <= BIT_WIDTH'(VALUE_BITS - 1);
          end else begin
            qnz    <= more;
            bitcnt <= bitcnt - BIT_WIDTH'(1);
          end
        end
        ST_EMIT: begin
          if (out_acc && !emit_done) begin
            cnt <= cnt - CNT_WIDTH'(1);
          end
        end
        default: ;
      endcase
    end
  end

  // Datapath: dividend/quotient, remainder and the digit stack
  always_ff @(posedge clk) begin
    if (in_acc) begin
      v     <= s_tdata[VALUE_BITS-1:0];
      radix <= in_base;
      rem   <= '0;
    end else if (state == ST_DIV) begin
      v   <= {v[VALUE_BITS-2:0], qbit};
      rem <= pass_done ? '0 : rem_next;
    end
    // push finished digit on top; pop on each delivered digit
    if (state == ST_DIV && pass_done) begin
      stk[0] <= rem_next;
      for (int i = 1; i < STACK_DEPTH; i++) begin
        stk[i] <= stk[i-1];
      end
    end else if (state == ST_EMIT && out_acc) begin
      for (int i = 0; i < STACK_DEPTH - 1; i++) begin
        stk[i] <= stk[i+1];
      end
    end
  end

endmodule
